### design/urrm_pkg.sv
`default_nettype none
// ============================================================================
// urrm_pkg
// shared types and constants of the uniform random rotation matrix core
// ============================================================================
package urrm_pkg;

    localparam int CORDIC_STEPS = 28;
    localparam int ROOT_BITS    = 31;                 // sqrt result width, Q0.30
    localparam int TRIG_BITS    = 32;                 // signed cordic outputs
    localparam int QUAT_BITS    = 32;                 // signed quaternion parts, Q.30
    localparam logic signed [TRIG_BITS-1:0] CORDIC_START = 32'sd652032874;

    typedef logic signed [TRIG_BITS-1:0] trig_t;
    typedef logic signed [QUAT_BITS-1:0] quat_t;

    typedef struct packed {
        quat_t w;
        quat_t i;
        quat_t j;
        quat_t k;
    } quat4_t;

    function automatic logic signed [TRIG_BITS-1:0] atan_turn(input int idx);
        logic signed [TRIG_BITS-1:0] v;
        case (idx)
            0: v = 32'sd536870912;
            1: v = 32'sd316933406;
            2: v = 32'sd167458907;
            3: v = 32'sd85004756;
            4: v = 32'sd42667331;
            5: v = 32'sd21354465;
            6: v = 32'sd10679838;
            7: v = 32'sd5340245;
            8: v = 32'sd2670163;
            9: v = 32'sd1335087;
            10: v = 32'sd667544;
            11: v = 32'sd333772;
            12: v = 32'sd166886;
            13: v = 32'sd83443;
            14: v = 32'sd41722;
            15: v = 32'sd20861;
            16: v = 32'sd10430;
            17: v = 32'sd5215;
            18: v = 32'sd2608;
            19: v = 32'sd1304;
            20: v = 32'sd652;
            21: v = 32'sd326;
            22: v = 32'sd163;
            23: v = 32'sd81;
            24: v = 32'sd41;
            25: v = 32'sd20;
            26: v = 32'sd10;
            27: v = 32'sd5;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### design/urrm_stream_if.sv
`default_nettype none
// ============================================================================
// urrm_stream_if
// valid/ready channel carrying a generic payload
// ============================================================================
interface urrm_stream_if #(
    parameter type PAYLOAD_T = logic
);
    logic     valid;
    logic     ready;
    PAYLOAD_T data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/urrm_sqrt_pipe.sv
`default_nettype none
// ============================================================================
// urrm_sqrt_pipe
// pipelined restoring square root, one result bit per stage
// ============================================================================
module urrm_sqrt_pipe #(
    parameter int STEPS = 31
) (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [2*STEPS-1:0] radicand,
    output logic [STEPS-1:0]       root
);
    import urrm_pkg::*;

    // per stage: remaining radicand, partial root (digit recurrence)
    logic [2*STEPS-1:0] rad_reg [STEPS+1];
    logic [STEPS+1:0]   rem_reg [STEPS+1];
    logic [STEPS-1:0]   res_reg [STEPS+1];

    always_comb
    begin
        rad_reg[0] = radicand;
        rem_reg[0] = '0;
        res_reg[0] = '0;
    end

    for (genvar s = 0; s < STEPS; s++) begin : g_stage
        logic [STEPS+1:0] rem_next;
        logic [STEPS+1:0] trial;
        always_comb
        begin
            rem_next = {rem_reg[s][STEPS-1:0], rad_reg[s][2*STEPS-1 -: 2]};
            trial    = {res_reg[s], 2'b01};
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[s+1] <= rad_reg[s] << 2;
                if (rem_next >= trial)
                begin
                    rem_reg[s+1] <= rem_next - trial;
                    res_reg[s+1] <= {res_reg[s][STEPS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s+1] <= rem_next;
                    res_reg[s+1] <= {res_reg[s][STEPS-2:0], 1'b0};
                end
            end
        end
    end

    assign root = res_reg[STEPS];
endmodule
`default_nettype wire

### design/urrm_cordic_pipe.sv
`default_nettype none
// ============================================================================
// urrm_cordic_pipe
// pipelined rotation-mode cordic with quadrant fold, one micro-rotation per stage
// ============================================================================
module urrm_cordic_pipe #(
    parameter int PIPE_LEN = 31
) (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] phase,
    output urrm_pkg::trig_t  cos_out,
    output urrm_pkg::trig_t  sin_out
);
    import urrm_pkg::*;

    trig_t      x_reg [CORDIC_STEPS+1];
    trig_t      y_reg [CORDIC_STEPS+1];
    trig_t      z_reg [CORDIC_STEPS+1];
    logic [1:0] q_reg [PIPE_LEN+1];
    trig_t      c_reg [PIPE_LEN-CORDIC_STEPS+1];
    trig_t      s_reg [PIPE_LEN-CORDIC_STEPS+1];

    always_comb
    begin
        x_reg[0] = CORDIC_START;
        y_reg[0] = '0;
        z_reg[0] = trig_t'({2'b00, phase[29:0]});
        q_reg[0] = phase[31:30];
    end

    for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_rot
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[s][TRIG_BITS-1])
                begin
                    x_reg[s+1] <= x_reg[s] - (y_reg[s] >>> s);
                    y_reg[s+1] <= y_reg[s] + (x_reg[s] >>> s);
                    z_reg[s+1] <= z_reg[s] - atan_turn(s);
                end
                else
                begin
                    x_reg[s+1] <= x_reg[s] + (y_reg[s] >>> s);
                    y_reg[s+1] <= y_reg[s] - (x_reg[s] >>> s);
                    z_reg[s+1] <= z_reg[s] + atan_turn(s);
                end
            end
        end
    end

    for (genvar s = 0; s < PIPE_LEN; s++) begin : g_quad
        always_ff @(posedge clk)
        begin
            if (en)
                q_reg[s+1] <= q_reg[s];
        end
    end

    // quadrant fold after the last micro-rotation
    always_comb
    begin
        case (q_reg[CORDIC_STEPS])
            2'd0:
            begin
                c_reg[0] = x_reg[CORDIC_STEPS];
                s_reg[0] = y_reg[CORDIC_STEPS];
            end
            2'd1:
            begin
                c_reg[0] = -y_reg[CORDIC_STEPS];
                s_reg[0] = x_reg[CORDIC_STEPS];
            end
            2'd2:
            begin
                c_reg[0] = -x_reg[CORDIC_STEPS];
                s_reg[0] = -y_reg[CORDIC_STEPS];
            end
            default:
            begin
                c_reg[0] = y_reg[CORDIC_STEPS];
                s_reg[0] = -x_reg[CORDIC_STEPS];
            end
        endcase
    end

    // delay line to match the square-root latency
    for (genvar s = 0; s < PIPE_LEN - CORDIC_STEPS; s++) begin : g_align
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                c_reg[s+1] <= c_reg[s];
                s_reg[s+1] <= s_reg[s];
            end
        end
    end

    assign cos_out = c_reg[PIPE_LEN-CORDIC_STEPS];
    assign sin_out = s_reg[PIPE_LEN-CORDIC_STEPS];
endmodule
`default_nettype wire

### design/urrm_matrix_pipe.sv
`default_nettype none
// ============================================================================
// urrm_matrix_pipe
// quaternion products, matrix sums, clamp and rounding to output format
// ============================================================================
module urrm_matrix_pipe #(
    parameter int OUT_FRAC_BITS = 30
) (
    input  wire logic                   clk,
    input  wire logic                   en,
    input  urrm_pkg::trig_t             ca,
    input  urrm_pkg::trig_t             sa,
    input  urrm_pkg::trig_t             cb,
    input  urrm_pkg::trig_t             sb,
    input  wire logic [urrm_pkg::ROOT_BITS-1:0] rx,
    input  wire logic [urrm_pkg::ROOT_BITS-1:0] r1x,
    output logic [9*(OUT_FRAC_BITS+2)-1:0] mat
);
    import urrm_pkg::*;

    localparam int OW = OUT_FRAC_BITS + 2;
    localparam logic signed [65:0] ONE60 = 66'sd1 <<< 60;

    // stage 1: quaternion parts
    logic signed [63:0] pw_reg, pi_reg, pj_reg, pk_reg;
    quat4_t q;
    // stage 2: pairwise products
    logic signed [63:0] ww_reg, ii_reg, jj_reg, kk_reg;
    logic signed [63:0] ij_reg, ik_reg, jk_reg, wi_reg, wj_reg, wk_reg;
    // stage 3: entries at Q.60
    logic signed [65:0] e_reg [9];
    logic signed [65:0] e_next [9];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pw_reg <= 64'(cb) * $signed({1'b0, rx});
            pi_reg <= 64'(sa) * $signed({1'b0, r1x});
            pj_reg <= 64'(ca) * $signed({1'b0, r1x});
            pk_reg <= 64'(sb) * $signed({1'b0, rx});
        end
    end

    always_comb
    begin
        q.w = quat_t'(pw_reg >>> 30);
        q.i = quat_t'(pi_reg >>> 30);
        q.j = quat_t'(pj_reg >>> 30);
        q.k = quat_t'(pk_reg >>> 30);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ww_reg <= 64'(q.w) * 64'(q.w);
            ii_reg <= 64'(q.i) * 64'(q.i);
            jj_reg <= 64'(q.j) * 64'(q.j);
            kk_reg <= 64'(q.k) * 64'(q.k);
            ij_reg <= 64'(q.i) * 64'(q.j);
            ik_reg <= 64'(q.i) * 64'(q.k);
            jk_reg <= 64'(q.j) * 64'(q.k);
            wi_reg <= 64'(q.w) * 64'(q.i);
            wj_reg <= 64'(q.w) * 64'(q.j);
            wk_reg <= 64'(q.w) * 64'(q.k);
        end
    end

    always_comb
    begin
        e_next[0] = ((66'(ww_reg) + 66'(ii_reg)) <<< 1) - ONE60;
        e_next[1] = (66'(ij_reg) - 66'(wk_reg)) <<< 1;
        e_next[2] = (66'(ik_reg) + 66'(wj_reg)) <<< 1;
        e_next[3] = (66'(ij_reg) + 66'(wk_reg)) <<< 1;
        e_next[4] = ((66'(ww_reg) + 66'(jj_reg)) <<< 1) - ONE60;
        e_next[5] = (66'(jk_reg) - 66'(wi_reg)) <<< 1;
        e_next[6] = (66'(ik_reg) - 66'(wj_reg)) <<< 1;
        e_next[7] = (66'(jk_reg) + 66'(wi_reg)) <<< 1;
        e_next[8] = ((66'(ww_reg) + 66'(kk_reg)) <<< 1) - ONE60;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            for (int n = 0; n < 9; n++)
                e_reg[n] <= e_next[n];
    end

    // stage 4: clamp and round half up
    for (genvar n = 0; n < 9; n++) begin : g_out
        logic signed [65:0] cl;
        logic signed [65+OUT_FRAC_BITS:0] rr;
        logic [OW-1:0] res_reg;
        always_comb
        begin
            if (e_reg[n] > ONE60)
                cl = ONE60;
            else if (e_reg[n] < -ONE60)
                cl = -ONE60;
            else
                cl = e_reg[n];
            if (OUT_FRAC_BITS >= 60)
                rr = (66+OUT_FRAC_BITS)'(cl) <<< (OUT_FRAC_BITS - 60);
            else
                rr = ((66+OUT_FRAC_BITS)'(cl)
                      + ((66+OUT_FRAC_BITS)'(1) <<< (59 - OUT_FRAC_BITS)))
                     >>> (60 - OUT_FRAC_BITS);
        end
        always_ff @(posedge clk)
        begin
            if (en)
                res_reg <= rr[OW-1:0];
        end
        assign mat[n*OW +: OW] = res_reg;
    end
endmodule
`default_nettype wire

### design/uniform_random_rotation_matrix_core.sv
`default_nettype none
// ============================================================================
// uniform_random_rotation_matrix_core
// Shoemake uniform random rotation matrix, fully pipelined
// ============================================================================
// Takes one transaction of three uniform samples per cycle, unless the output
// stalls, and returns the 3x3 rotation matrix in signed Q1.OUT_FRAC_BITS,
// entries saturated to +-1, at the same rate. The 31-stage digit-by-digit
// square root (the 28-stage cordic is delay-matched to it) is followed by
// four stages of multiply, product, sum and rounding.
// The whole pipe advances when the output register is empty or being taken,
// so a stall at the output freezes every stage and nothing is lost or repeated.
module uniform_random_rotation_matrix_core #(
    parameter int SAMPLE_BITS   = 32,
    parameter int OUT_FRAC_BITS = 30
) (
    input  wire logic clk,
    input  wire logic rst_n,
    urrm_stream_if.sink   in_if,
    urrm_stream_if.source out_if
);
    import urrm_pkg::*;

    localparam int SQ_STEPS = ROOT_BITS;
    localparam int MAT_LAT  = 4;
    localparam int LAT      = SQ_STEPS + MAT_LAT;
    localparam int OW       = OUT_FRAC_BITS + 2;

    logic en;
    logic [LAT-1:0] vld_reg;
    logic [SAMPLE_BITS-1:0] sx, sa, sb;
    logic [61:0] x60, y60;
    logic [31:0] pha, phb;
    logic [ROOT_BITS-1:0] rx, r1x;
    trig_t ca, sna, cb, snb;

    // output register stage is the last vld bit; advance unless it is stalled
    assign en = !vld_reg[LAT-1] || out_if.ready;
    assign in_if.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_if.valid};
    end

    // pick the used sample bits
    assign sx = SAMPLE_BITS'(in_if.data[95:64]);
    assign sa = SAMPLE_BITS'(in_if.data[63:32]);
    assign sb = SAMPLE_BITS'(in_if.data[31:0]);

    // x as Q0.60, 1-x likewise (at most 2^60, fits 62 bits)
    assign x60 = 62'(sx) << (60 - SAMPLE_BITS);
    assign y60 = (62'(1) << 60) - x60;

    // phase in units of 2^-32 turn
    if (SAMPLE_BITS >= 32) begin : g_ph_trunc
        assign pha = sa[SAMPLE_BITS-1 -: 32];
        assign phb = sb[SAMPLE_BITS-1 -: 32];
    end else begin : g_ph_ext
        assign pha = {sa, {(32-SAMPLE_BITS){1'b0}}};
        assign phb = {sb, {(32-SAMPLE_BITS){1'b0}}};
    end

    urrm_sqrt_pipe #(.STEPS(SQ_STEPS)) u_sqrt_x (
        .clk(clk), .en(en), .radicand(x60), .root(rx)
    );
    urrm_sqrt_pipe #(.STEPS(SQ_STEPS)) u_sqrt_1mx (
        .clk(clk), .en(en), .radicand(y60), .root(r1x)
    );
    urrm_cordic_pipe #(.PIPE_LEN(SQ_STEPS)) u_cordic_a (
        .clk(clk), .en(en), .phase(pha), .cos_out(ca), .sin_out(sna)
    );
    urrm_cordic_pipe #(.PIPE_LEN(SQ_STEPS)) u_cordic_b (
        .clk(clk), .en(en), .phase(phb), .cos_out(cb), .sin_out(snb)
    );

    logic [9*OW-1:0] mat;
    urrm_matrix_pipe #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_matrix (
        .clk(clk), .en(en), .ca(ca), .sa(sna), .cb(cb), .sb(snb),
        .rx(rx), .r1x(r1x), .mat(mat)
    );

    assign out_if.valid = vld_reg[LAT-1];
    assign out_if.data  = mat;

    // a stalled result must hold its valid
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_if.valid && !out_if.ready |=> out_if.valid)
        else $error("result dropped while stalled");
    // input is open whenever the output register is empty
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_if.valid |-> in_if.ready)
        else $error("input blocked with empty output");
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during stall");
endmodule
`default_nettype wire

### test/urrm_tb_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// urrm_tb_pkg
// transaction types shared by the rotation matrix testbench and its checker
// ============================================================================
package urrm_tb_pkg;

    typedef struct packed {
        logic [31:0] sample_x;
        logic [31:0] sample_angle_a;
        logic [31:0] sample_angle_b;
    } samples_t;

    // m00 sits in the low bits, m22 in the high bits
    typedef struct packed {
        logic signed [31:0] m22;
        logic signed [31:0] m21;
        logic signed [31:0] m20;
        logic signed [31:0] m12;
        logic signed [31:0] m11;
        logic signed [31:0] m10;
        logic signed [31:0] m02;
        logic signed [31:0] m01;
        logic signed [31:0] m00;
    } matrix_t;

endpackage

### test/urrm_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// urrm_checker
// predicts each rotation matrix from its samples and compares the output
// ============================================================================
module urrm_checker
    import urrm_pkg::*;
    import urrm_tb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    urrm_stream_if    in_if,
    urrm_stream_if    out_if,
    output int        fail_count,
    output int        pending
);

    localparam longint ONE_Q60 = 64'sd1 << 60;

    matrix_t matrix_queue[$];

    // digit-by-digit integer square root
    function automatic longint isqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    function automatic void turn_trig(input logic [31:0] phase, output longint c,
                                      output longint s);
        longint x;
        longint y;
        longint z;
        longint nx;
        x = longint'(CORDIC_START);
        y = 0;
        z = longint'(phase[29:0]);
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(atan_turn(i));
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(atan_turn(i));
            end
            x = nx;
        end
        case (phase[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic logic signed [31:0] to_q30(input longint v);
        longint r;
        if (v > ONE_Q60)
            v = ONE_Q60;
        if (v < -ONE_Q60)
            v = -ONE_Q60;
        r = (v + (64'sd1 << 29)) >>> 30;
        return r[31:0];
    endfunction

    function automatic matrix_t rotation_of(input samples_t s);
        logic [63:0] x60;
        longint      rx, r1x, ca, sa, cb, sb, w, qi, qj, qk;
        matrix_t     m;
        x60 = {s.sample_x, 28'd0};
        rx  = isqrt(x60);
        r1x = isqrt((64'd1 << 60) - x60);
        turn_trig(s.sample_angle_a, ca, sa);
        turn_trig(s.sample_angle_b, cb, sb);
        w  = (cb * rx) >>> 30;
        qi = (sa * r1x) >>> 30;
        qj = (ca * r1x) >>> 30;
        qk = (sb * rx) >>> 30;
        m.m00 = to_q30(2 * (w * w + qi * qi) - ONE_Q60);
        m.m01 = to_q30(2 * (qi * qj - w * qk));
        m.m02 = to_q30(2 * (qi * qk + w * qj));
        m.m10 = to_q30(2 * (qj * qi + w * qk));
        m.m11 = to_q30(2 * (w * w + qj * qj) - ONE_Q60);
        m.m12 = to_q30(2 * (qj * qk - w * qi));
        m.m20 = to_q30(2 * (qk * qi - w * qj));
        m.m21 = to_q30(2 * (qk * qj + w * qi));
        m.m22 = to_q30(2 * (w * w + qk * qk) - ONE_Q60);
        return m;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, $signed(got),
                 $signed(want), $time);
        fail_count++;
    endtask

    initial fail_count = 0;
    assign pending = matrix_queue.size();

    always @(posedge clk)
    begin
        matrix_t               got;
        matrix_t               want;
        logic [8:0][31:0]      got_v;
        logic [8:0][31:0]      want_v;
        string                 names[9];
        names = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};
        if (rst_n && in_if.valid && in_if.ready)
            matrix_queue.push_back(rotation_of(in_if.data));
        if (rst_n && out_if.valid && out_if.ready)
        begin
            got = out_if.data;
            if (matrix_queue.size() == 0)
                report("unexpected transaction", 32'd0, 32'd0);
            else
            begin
                want   = matrix_queue.pop_front();
                got_v  = got;
                want_v = want;
                for (int f = 0; f < 9; f++)
                    if (got_v[f] !== want_v[f])
                        report(names[f], got_v[f], want_v[f]);
            end
        end
    end

endmodule

### test/uniform_random_rotation_matrix_core_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// uniform_random_rotation_matrix_core_tb
// stimulus and verdict for the rotation matrix core
// ============================================================================
// drives sample triples through the core under several idling patterns,
// directed corner samples first, then random ones; a checker beside the
// core predicts every matrix and compares it entry by entry
module uniform_random_rotation_matrix_core_tb;
    import urrm_tb_pkg::*;

    localparam int RANDOM_ITEMS = 1750;
    localparam int WATCHDOG     = 5000;    // idle cycles, far beyond the pipeline depth
    localparam int DRAIN        = 60;

    // idling patterns
    typedef enum int { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } idle_mode_t;

    logic       clk;
    logic       rst_n;
    idle_mode_t mode;
    int         fail_count;
    int         pending;
    int         quiet_cycles;

    urrm_stream_if #(.PAYLOAD_T(samples_t)) in_if ();
    urrm_stream_if #(.PAYLOAD_T(matrix_t))  out_if ();

    uniform_random_rotation_matrix_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_if  (in_if),
        .out_if (out_if)
    );

    urrm_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_if      (in_if),
        .out_if     (out_if),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // receiver: stalls with 83 percent odds in receive idling, 15 percent in both
    always @(posedge clk)
    begin
        if (mode == IDLE_RECV)
            out_if.ready <= ($urandom_range(99) >= 83);
        else if (mode == IDLE_BOTH)
            out_if.ready <= ($urandom_range(99) >= 15);
        else
            out_if.ready <= 1'b1;
    end

    // watchdog: ends the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("uniform_random_rotation_matrix_core verification failed");
            $finish;
        end
    end

    // one transaction; valid stays high into the next call so back-to-back
    // items never see valid dropped and raised in the same step
    task automatic send(input samples_t s);
        while ((mode == IDLE_SEND && $urandom_range(99) < 83) ||
               (mode == IDLE_BOTH && $urandom_range(99) < 15))
        begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= s;
        do
            @(posedge clk);
        while (!in_if.ready);
    endtask

    function automatic logic [31:0] rand_angle();
        logic [31:0] a;
        a = $urandom;
        // now and then land right next to a quadrant boundary
        if ($urandom_range(7) == 0)
            a = {a[31:30], 30'd0} + 32'($signed($urandom_range(8)) - 4);
        return a;
    endfunction

    function automatic logic [31:0] rand_x();
        case ($urandom_range(9))
            0: return $urandom_range(255);                  // near zero
            1: return 32'hFFFF_FFFF - $urandom_range(255);  // near one
            default: return $urandom;
        endcase
    endfunction

    // pause the sender until every expected matrix is back
    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] corner[8];
        samples_t    s;
        mode         = IDLE_NONE;
        quiet_cycles = 0;
        rst_n        = 1'b0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners: zero and full x, every quadrant boundary, all ones
        corner = '{32'h0000_0000, 32'h4000_0000, 32'h8000_0000, 32'hC000_0000,
                   32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA};
        for (int i = 0; i < 8; i++)
        begin
            s.sample_x       = corner[i];
            s.sample_angle_a = corner[(i + 1) % 8];
            s.sample_angle_b = corner[(i + 3) % 8];
            send(s);
        end
        for (int i = 0; i < 8; i++)
        begin
            s.sample_x       = (i % 2) ? 32'hFFFF_FFFF : 32'h0000_0000;
            s.sample_angle_a = corner[i];
            s.sample_angle_b = corner[7 - i];
            send(s);
        end
        drain();

        // random phases, one per idling pattern plus a clean one at the end
        for (int p = 0; p < 5; p++)
        begin
            mode = idle_mode_t'(p % 4);
            for (int n = 0; n < RANDOM_ITEMS / 5; n++)
            begin
                s.sample_x       = rand_x();
                s.sample_angle_a = rand_angle();
                s.sample_angle_b = rand_angle();
                send(s);
            end
            drain();
        end

        mode = IDLE_NONE;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (fail_count == 0)
            $display("uniform_random_rotation_matrix_core verification clean");
        else
            $display("uniform_random_rotation_matrix_core verification failed");
        $finish;
    end

endmodule
